@@ sv/assert_macros.svh @@
// Assertion helpers for the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/cic_pkg.sv @@
package cic_pkg;

  // CPU levels fed by the cascade and the serial lines
  localparam int VIA_CPU_LEVEL    = 2;
  localparam int SERIAL_CPU_LEVEL = 4;
  // summary bit of the drive flag register
  localparam int DRIVE_IRQ_BIT    = 7;

  localparam logic [7:0] DRV_EN_MASK  = 8'h03;
  localparam logic [7:0] DRV_SUM_MASK = 8'(1 << DRIVE_IRQ_BIT);
  localparam logic [6:0] SLOT_IDLE    = 7'h7F;

  // register indexes
  localparam logic [4:0] REG_VIA_FLAGS = 5'd13;
  localparam logic [4:0] REG_VIA_EN    = 5'd14;
  localparam logic [4:0] REG_SLOT      = 5'd15;
  localparam logic [4:0] REG_DRV_CLR   = 5'd16;
  localparam logic [4:0] REG_DRV_FLAGS = 5'd17;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_LINE  = 2'd2,
    REQ_ACK   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    GRP_SERIAL = 3'd0,
    GRP_DRIVE  = 3'd1,
    GRP_SLOT   = 3'd2,
    GRP_VIA    = 3'd3,
    GRP_CPU    = 3'd4
  } grp_e;

  typedef struct packed {
    req_e       req_type;
    logic [4:0] reg_index;
    logic [7:0] wdata;
    logic [2:0] src_group;
    logic [7:0] src_mask;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       cpu_request;
    logic [2:0] int_level;
  } result_t;

  typedef struct packed {
    logic [7:0] via_flags;
    logic [6:0] via_enables;
    logic [6:0] slot_flags_n;
    logic [6:0] slot_enables;
    logic [7:0] drive_flags;
    logic       drive_out;
    logic       slot_any;
    logic       via_out;
    logic [1:0] serial_lines;
    logic [7:0] cpu_levels;
    logic [2:0] served_level;
    logic       cpu_req;
  } state_t;

endpackage

@@ sv/cic_cascade.sv @@
module cic_cascade (
  input  cic_pkg::state_t  state_i,
  input  cic_pkg::item_t   item_i,
  input  logic [7:0]       file_rdata_i,
  output cic_pkg::state_t  state_o,
  output cic_pkg::result_t result_o,
  output logic             file_we_o
);

  function automatic logic [2:0] cur_level(logic [7:0] lv);
    logic [2:0] r;
    r = '0;
    for (int i = 1; i < 8; i++) begin
      if (lv[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic cic_pkg::state_t via_eval(cic_pkg::state_t s);
    cic_pkg::state_t t;
    logic act;
    t = s;
    act = |(t.via_flags[6:0] & t.via_enables);
    t.via_flags[7] = act;
    if (act != t.via_out) begin
      t.via_out = act;
      t.cpu_levels[cic_pkg::VIA_CPU_LEVEL] = act;
    end
    return t;
  endfunction

  function automatic cic_pkg::state_t slot_eval(cic_pkg::state_t s);
    cic_pkg::state_t t;
    logic act;
    t = s;
    act = |(~t.slot_flags_n);
    if (act != t.slot_any) begin
      t.slot_any = act;
      t.via_flags[1] = act;
      t = via_eval(t);
    end
    return t;
  endfunction

  function automatic cic_pkg::state_t drive_eval(cic_pkg::state_t s);
    cic_pkg::state_t t;
    logic act;
    t = s;
    act = (|(t.drive_flags & ~(cic_pkg::DRV_EN_MASK | cic_pkg::DRV_SUM_MASK)))
        && (|(t.drive_flags & cic_pkg::DRV_EN_MASK));
    t.drive_flags[cic_pkg::DRIVE_IRQ_BIT] = act;
    if (act != t.drive_out) begin
      t.drive_out = act;
      t.slot_flags_n[0] = ~act;
      t = slot_eval(t);
    end
    return t;
  endfunction

  always_comb begin
    cic_pkg::state_t s;
    logic [7:0] rd;
    logic [7:0] m;
    s = state_i;
    rd = '0;
    m = '0;
    file_we_o = 1'b0;
    case (item_i.req_type)
      cic_pkg::REQ_READ: begin
        if (item_i.reg_index == cic_pkg::REG_VIA_FLAGS) rd = s.via_flags;
        else if (item_i.reg_index == cic_pkg::REG_VIA_EN) rd = {1'b1, s.via_enables};
        else if (item_i.reg_index == cic_pkg::REG_SLOT) rd = {1'b0, s.slot_flags_n};
        else if (!item_i.reg_index[4]) rd = file_rdata_i;
        else if (item_i.reg_index == cic_pkg::REG_DRV_FLAGS) rd = s.drive_flags;
      end
      cic_pkg::REQ_WRITE: begin
        if (item_i.reg_index == cic_pkg::REG_VIA_FLAGS) begin
          s.via_flags[6:0] = s.via_flags[6:0] & ~item_i.wdata[6:0];
          s = via_eval(s);
        end else if (item_i.reg_index == cic_pkg::REG_VIA_EN) begin
          if (item_i.wdata[7]) s.via_enables = s.via_enables | item_i.wdata[6:0];
          else s.via_enables = s.via_enables & ~item_i.wdata[6:0];
          s = via_eval(s);
        end else if (item_i.reg_index == cic_pkg::REG_SLOT) begin
          if (item_i.wdata[7]) s.slot_enables = s.slot_enables | item_i.wdata[6:0];
          else s.slot_enables = s.slot_enables & ~item_i.wdata[6:0];
        end else if (!item_i.reg_index[4]) begin
          file_we_o = 1'b1;
        end else if (item_i.reg_index == cic_pkg::REG_DRV_CLR) begin
          s.drive_flags = s.drive_flags & ~item_i.wdata;
          s = drive_eval(s);
        end else if (item_i.reg_index == cic_pkg::REG_DRV_FLAGS) begin
          s.drive_flags = (s.drive_flags & ~(item_i.wdata & ~cic_pkg::DRV_EN_MASK))
                        | (item_i.wdata & cic_pkg::DRV_EN_MASK);
          s = drive_eval(s);
        end
      end
      cic_pkg::REQ_LINE: begin
        case (item_i.src_group)
          cic_pkg::GRP_SERIAL: begin
            if (item_i.line_level) s.serial_lines = s.serial_lines | item_i.src_mask[1:0];
            else s.serial_lines = s.serial_lines & ~item_i.src_mask[1:0];
            s.cpu_levels[cic_pkg::SERIAL_CPU_LEVEL] = |s.serial_lines;
          end
          cic_pkg::GRP_DRIVE: begin
            m = item_i.src_mask & ~(cic_pkg::DRV_EN_MASK | cic_pkg::DRV_SUM_MASK);
            if (item_i.line_level) s.drive_flags = s.drive_flags | m;
            else s.drive_flags = s.drive_flags & ~m;
            s = drive_eval(s);
          end
          cic_pkg::GRP_SLOT: begin
            if (item_i.line_level) s.slot_flags_n = s.slot_flags_n & ~item_i.src_mask[6:0];
            else s.slot_flags_n = s.slot_flags_n | item_i.src_mask[6:0];
            s = slot_eval(s);
          end
          cic_pkg::GRP_VIA: begin
            if (item_i.line_level) s.via_flags[6:0] = s.via_flags[6:0] | item_i.src_mask[6:0];
            else s.via_flags[6:0] = s.via_flags[6:0] & ~item_i.src_mask[6:0];
            s = via_eval(s);
          end
          cic_pkg::GRP_CPU: begin
            if (item_i.line_level) s.cpu_levels = s.cpu_levels | item_i.src_mask;
            else s.cpu_levels = s.cpu_levels & ~item_i.src_mask;
          end
          default: begin
          end
        endcase
      end
      cic_pkg::REQ_ACK: begin
        s.served_level = cur_level(s.cpu_levels);
        s.cpu_req = 1'b0;
      end
      default: begin
      end
    endcase
    if (cur_level(s.cpu_levels) != s.served_level) s.cpu_req = 1'b1;
    state_o = s;
    result_o.rdata = rd;
    result_o.cpu_request = s.cpu_req;
    result_o.int_level = cur_level(s.cpu_levels);
  end

endmodule

@@ sv/cascaded_interrupt_controller.sv @@
// Cascaded interrupt controller: drive flags -> slot flags -> VIA flag/enable
// pair -> CPU level register, with two serial lines on their own CPU level.
//
// Requests come in on the s_axis channel: tuser carries the kind (register
// read, register write, source line change, CPU acknowledge) and tdata the
// register index, write byte, source group, line mask and line level. Each
// request yields exactly one result on the m_axis channel: read data (zero
// for anything but a read), the CPU request line and the highest active level.
//
// Flow: the accepting edge loads the input register; once the result register
// is free, the request is pushed through the cascade into the result register.
// Throughput is one request per cycle while the receiver takes each result; the
// whole cascade settles in a single pass of logic between those two registers,
// updating the state at the same edge that loads the result.
//
// Reset clears all flags, enables, levels and the 16-byte register file, and
// sets every active-low slot line idle. When the receiver stalls, the result
// holds and the input register still accepts one more request; after that
// s_axis_tready_o drops until the result is taken.
`include "assert_macros.svh"

module cascaded_interrupt_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [4:0] reg_index, [12:5] wdata, [15:13] src_group, [23:16] src_mask,
  // [24] line_level, [31:25] zero
  input  logic [31:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] rdata, [8] cpu_request, [11:9] int_level, [15:12] zero
  output logic [15:0] m_axis_tdata_o
);

  cic_pkg::item_t   in_q;
  logic             in_vld_q;
  cic_pkg::result_t out_q, out_d;
  logic             out_vld_q;
  cic_pkg::state_t  state_q, state_d;
  logic [7:0]       via_file_q [16];
  logic             file_we;
  logic             advance;

  // Move the held request through the cascade when the result slot frees up.
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  // Capture the request; payload needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.req_type   <= cic_pkg::req_e'(s_axis_tuser_i);
      in_q.reg_index  <= s_axis_tdata_i[4:0];
      in_q.wdata      <= s_axis_tdata_i[12:5];
      in_q.src_group  <= s_axis_tdata_i[15:13];
      in_q.src_mask   <= s_axis_tdata_i[23:16];
      in_q.line_level <= s_axis_tdata_i[24];
    end
  end

  cic_cascade u_cascade (
    .state_i      (state_q),
    .item_i       (in_q),
    .file_rdata_i (via_file_q[in_q.reg_index[3:0]]),
    .state_o      (state_d),
    .result_o     (out_d),
    .file_we_o    (file_we)
  );

  // Commit the cascade state and the register file together with the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{slot_flags_n: cic_pkg::SLOT_IDLE, default: '0};
      for (int i = 0; i < 16; i++) begin
        via_file_q[i] <= '0;
      end
    end else if (advance) begin
      state_q <= state_d;
      if (file_we) begin
        via_file_q[in_q.reg_index[3:0]] <= in_q.wdata;
      end
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.int_level, out_q.cpu_request, out_q.rdata};

  // The VIA summary bit always mirrors the VIA output to the CPU.
  `ASSERT_IMPL(a_via_summary, clk_i, rst_ni, 1'b1, state_q.via_flags[7] == state_q.via_out)
  // The drive summary bit always mirrors the drive output to the slot stage.
  `ASSERT_IMPL(a_drive_summary, clk_i, rst_ni, 1'b1,
               state_q.drive_flags[cic_pkg::DRIVE_IRQ_BIT] == state_q.drive_out)
  // The slot output follows its active-low lines.
  `ASSERT_IMPL(a_slot_any, clk_i, rst_ni, 1'b1, state_q.slot_any == (|(~state_q.slot_flags_n)))
  // A quiet request line means the shown level is the acknowledged one.
  `ASSERT_IMPL(a_req_quiet, clk_i, rst_ni, out_vld_q && !out_q.cpu_request,
               out_q.int_level == state_q.served_level)
  // A held request is never dropped while the result slot is full.
  `ASSERT_NEXT(a_hold_req, clk_i, rst_ni, in_vld_q && !advance, in_vld_q)

endmodule

@@ verif/cascaded_interrupt_controller_tb.sv @@
module cascaded_interrupt_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         RUN_LIMIT     = 200_000;
  localparam int         ITEMS_PER_RUN = 517;
  localparam int         MAX_REPORTS   = 10;
  // register and group codes outside the named ones in the package
  localparam logic [4:0] REG_FILE_BASE = 5'd0;
  localparam logic [4:0] REG_TOP       = 5'd31;
  localparam logic [4:0] REG_NONE_LO   = 5'd18;
  localparam logic [2:0] GRP_NONE      = 3'd7;
  localparam logic [2:0] GRP_NONE_LO   = 3'd5;
  // bit positions inside the cascade
  localparam int         SLOT_DRIVE_BIT = 0;
  localparam int         VIA_SLOT_BIT   = 1;
  localparam int         VIA_SUM_BIT    = 7;

  typedef struct {
    cic_pkg::item_t   it;
    bit               typed;
    cic_pkg::result_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [15:0] m_axis_tdata_o;

  cascaded_interrupt_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the cascade state, advanced once per accepted request
  logic [7:0] via_regs [16];
  logic [7:0] via_flags;
  logic [6:0] via_en;
  logic [6:0] slot_n;
  logic [6:0] slot_en;
  logic [7:0] drv_flags;
  logic       drv_out;
  logic       slot_any;
  logic       via_out;
  logic [1:0] serial_lines;
  logic [7:0] cpu_levels;
  logic [2:0] served_level;
  logic       cpu_req;

  cic_pkg::result_t irq_results_due [$];
  stim_row_t        dir_rows [$];
  int               send_idle_pct = 32;
  int               recv_idle_pct = 61;
  int               mismatches = 0;
  int               checked = 0;
  int               cycles = 0;
  int               n_reads = 0, n_writes = 0, n_lines = 0, n_acks = 0, n_rises = 0;
  cic_pkg::result_t due_res, seen_res;

  function automatic logic [2:0] top_level(input logic [7:0] lv);
    logic [2:0] r;
    r = '0;
    for (int i = 1; i < 8; i++) if (lv[i]) r = 3'(i);
    return r;
  endfunction

  // Summary of the VIA pair feeds its CPU level
  function automatic void via_update();
    logic act;
    act = |(via_flags[6:0] & via_en);
    via_flags[VIA_SUM_BIT] = act;
    if (act != via_out) begin
      via_out = act;
      cpu_levels[cic_pkg::VIA_CPU_LEVEL] = act;
    end
  endfunction

  // Any active-low slot line raises the slot flag of the VIA pair
  function automatic void slot_update();
    logic act;
    act = |(~slot_n);
    if (act != slot_any) begin
      slot_any = act;
      via_flags[VIA_SLOT_BIT] = act;
      via_update();
    end
  endfunction

  // Drive summary: a pending source with either enable set pulls slot line 0
  function automatic void drive_update();
    logic act;
    act = ((drv_flags & ~(cic_pkg::DRV_EN_MASK | cic_pkg::DRV_SUM_MASK)) != '0) &&
          ((drv_flags & cic_pkg::DRV_EN_MASK) != '0);
    drv_flags[cic_pkg::DRIVE_IRQ_BIT] = act;
    if (act != drv_out) begin
      drv_out = act;
      slot_n[SLOT_DRIVE_BIT] = ~act;
      slot_update();
    end
  endfunction

  function automatic cic_pkg::result_t cascade_step(input cic_pkg::item_t it);
    cic_pkg::result_t r;
    logic [7:0]       wd;
    logic [7:0]       m;
    wd = it.wdata;
    r  = '0;
    case (it.req_type)
      cic_pkg::REQ_READ: begin
        case (it.reg_index)
          cic_pkg::REG_VIA_FLAGS: r.rdata = via_flags;
          cic_pkg::REG_VIA_EN:    r.rdata = {1'b1, via_en};
          cic_pkg::REG_SLOT:      r.rdata = {1'b0, slot_n};
          cic_pkg::REG_DRV_FLAGS: r.rdata = drv_flags;
          default: begin
            if (it.reg_index < cic_pkg::REG_DRV_CLR) r.rdata = via_regs[it.reg_index[3:0]];
          end
        endcase
      end
      cic_pkg::REQ_WRITE: begin
        case (it.reg_index)
          cic_pkg::REG_VIA_FLAGS: begin
            via_flags[6:0] = via_flags[6:0] & ~wd[6:0];
            via_update();
          end
          cic_pkg::REG_VIA_EN: begin
            via_en = wd[7] ? (via_en | wd[6:0]) : (via_en & ~wd[6:0]);
            via_update();
          end
          cic_pkg::REG_SLOT: slot_en = wd[7] ? (slot_en | wd[6:0]) : (slot_en & ~wd[6:0]);
          cic_pkg::REG_DRV_CLR: begin
            drv_flags = drv_flags & ~wd;
            drive_update();
          end
          cic_pkg::REG_DRV_FLAGS: begin
            drv_flags = (drv_flags & ~(wd & ~cic_pkg::DRV_EN_MASK)) | (wd & cic_pkg::DRV_EN_MASK);
            drive_update();
          end
          default: begin
            if (it.reg_index < cic_pkg::REG_DRV_CLR) via_regs[it.reg_index[3:0]] = wd;
          end
        endcase
      end
      cic_pkg::REQ_LINE: begin
        m = it.src_mask;
        case (it.src_group)
          cic_pkg::GRP_SERIAL: begin
            serial_lines = it.line_level ? (serial_lines | m[1:0]) : (serial_lines & ~m[1:0]);
            cpu_levels[cic_pkg::SERIAL_CPU_LEVEL] = |serial_lines;
          end
          cic_pkg::GRP_DRIVE: begin
            m = m & ~(cic_pkg::DRV_EN_MASK | cic_pkg::DRV_SUM_MASK);
            drv_flags = it.line_level ? (drv_flags | m) : (drv_flags & ~m);
            drive_update();
          end
          cic_pkg::GRP_SLOT: begin
            slot_n = it.line_level ? (slot_n & ~m[6:0]) : (slot_n | m[6:0]);
            slot_update();
          end
          cic_pkg::GRP_VIA: begin
            via_flags[6:0] = it.line_level ? (via_flags[6:0] | m[6:0])
                                           : (via_flags[6:0] & ~m[6:0]);
            via_update();
          end
          cic_pkg::GRP_CPU: cpu_levels = it.line_level ? (cpu_levels | m) : (cpu_levels & ~m);
          default: ;
        endcase
      end
      default: begin
        served_level = top_level(cpu_levels);
        cpu_req      = 1'b0;
      end
    endcase
    if (top_level(cpu_levels) != served_level) cpu_req = 1'b1;
    r.cpu_request = cpu_req;
    r.int_level   = top_level(cpu_levels);
    return r;
  endfunction

  function automatic void add_row(input cic_pkg::req_e k, input logic [4:0] ri,
                                  input logic [7:0] wd, input logic [2:0] g,
                                  input logic [7:0] m, input logic lvl,
                                  input bit typed, input logic [7:0] rd, input logic rq,
                                  input logic [2:0] il);
    stim_row_t row;
    row.it        = '{req_type: k, reg_index: ri, wdata: wd, src_group: g,
                      src_mask: m, line_level: lvl};
    row.typed     = typed;
    row.want      = '{rdata: rd, cpu_request: rq, int_level: il};
    dir_rows.push_back(row);
  endfunction

  // Pick a register index: mostly the cascade registers, some file bytes, a few unused
  function automatic logic [4:0] pick_reg();
    int p;
    p = $urandom_range(9);
    if (p < 6) return 5'($urandom_range(cic_pkg::REG_VIA_FLAGS, cic_pkg::REG_DRV_FLAGS));
    if (p < 9) return 5'($urandom_range(REG_FILE_BASE, cic_pkg::REG_SLOT));
    return 5'($urandom_range(REG_NONE_LO, REG_TOP));
  endfunction

  function automatic cic_pkg::item_t random_request();
    cic_pkg::item_t it;
    int             p;
    it.reg_index  = pick_reg();
    it.wdata      = 8'($urandom);
    it.src_group  = ($urandom_range(19) == 0)
                  ? 3'($urandom_range(GRP_NONE_LO, GRP_NONE))
                  : 3'($urandom_range(cic_pkg::GRP_SERIAL, cic_pkg::GRP_CPU));
    // single-bit masks now and then, so lines release one at a time
    it.src_mask   = ($urandom_range(3) == 0) ? 8'(1 << $urandom_range(7)) : 8'($urandom);
    it.line_level = 1'($urandom);
    p = $urandom_range(99);
    if (p < 10)      it.req_type = cic_pkg::REQ_ACK;
    else if (p < 35) it.req_type = cic_pkg::REQ_READ;
    else if (p < 65) it.req_type = cic_pkg::REQ_WRITE;
    else             it.req_type = cic_pkg::REQ_LINE;
    return it;
  endfunction

  // Present one request, hold it until taken, then queue its expected result
  task automatic push_request(input cic_pkg::item_t it, input bit typed,
                              input cic_pkg::result_t want);
    cic_pkg::result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.req_type;
    s_tdata  <= {7'b0, it.line_level, it.src_mask, it.src_group, it.wdata, it.reg_index};
    do @(posedge clk_i); while (!s_axis_tready_o);
    got = cascade_step(it);
    irq_results_due.push_back(typed ? want : got);
    case (it.req_type)
      cic_pkg::REQ_READ:  n_reads++;
      cic_pkg::REQ_WRITE: n_writes++;
      cic_pkg::REQ_LINE:  n_lines++;
      default:            n_acks++;
    endcase
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (irq_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall at random, compare every taken result with the oldest one due
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid_o && m_tready) begin
        seen_res = '{rdata: m_axis_tdata_o[7:0], cpu_request: m_axis_tdata_o[8],
                     int_level: m_axis_tdata_o[11:9]};
        if (irq_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result rdata %h cpu_request %b int_level %0d",
                     $realtime, seen_res.rdata, seen_res.cpu_request, seen_res.int_level);
        end else begin
          due_res = irq_results_due.pop_front();
          checked++;
          if (due_res.cpu_request) n_rises++;
          if (seen_res.rdata != due_res.rdata ||
              seen_res.cpu_request != due_res.cpu_request ||
              seen_res.int_level != due_res.int_level) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result %0d: rdata exp %h got %h, %s exp %b got %b, %s %0d got %0d",
                       $realtime, checked, due_res.rdata, seen_res.rdata, "cpu_request",
                       due_res.cpu_request, seen_res.cpu_request, "int_level exp",
                       due_res.int_level, seen_res.int_level);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               irq_results_due.size());
      $display("cascaded_interrupt_controller_tb: errors");
      $finish;
    end
  end

  initial begin
    foreach (via_regs[i]) via_regs[i] = '0;
    via_flags    = '0;
    via_en       = '0;
    slot_n       = cic_pkg::SLOT_IDLE;
    slot_en      = '0;
    drv_flags    = '0;
    drv_out      = 1'b0;
    slot_any     = 1'b0;
    via_out      = 1'b0;
    serial_lines = '0;
    cpu_levels   = '0;
    served_level = '0;
    cpu_req      = 1'b0;

    // Reset-state reads and the unused corners, expectations written out
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_VIA_EN, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h80, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_SLOT, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h7F, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_VIA_FLAGS, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_DRV_FLAGS, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_DRV_CLR, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_READ, REG_TOP, 8'hFF, GRP_NONE, 8'hFF,
            1'b1, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_ACK, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_WRITE, REG_FILE_BASE, 8'hFF, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_READ, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'hFF, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_WRITE, REG_TOP, 8'hFF, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 1, 8'h00, 1'b0, 3'd0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, GRP_NONE, 8'hFF,
            1'b1, 1, 8'h00, 1'b0, 3'd0);
    // Walk a drive source all the way up the cascade, then the other sources
    add_row(cic_pkg::REQ_WRITE, cic_pkg::REG_VIA_EN, 8'h82, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_WRITE, cic_pkg::REG_DRV_FLAGS, 8'h03, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_DRIVE, 8'hFF,
            1'b1, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_DRV_FLAGS, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_SLOT, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_READ, cic_pkg::REG_VIA_FLAGS, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_ACK, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SERIAL, 8'hFF,
            1'b1, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_CPU, 8'hFF,
            1'b1, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_ACK, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_CPU, 8'hFF,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_WRITE, cic_pkg::REG_DRV_CLR, 8'hFF, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SLOT, 8'h7F,
            1'b1, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_VIA, 8'hFF,
            1'b1, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_WRITE, cic_pkg::REG_VIA_FLAGS, 8'hFF, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_WRITE, cic_pkg::REG_SLOT, 8'h8F, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_WRITE, cic_pkg::REG_VIA_EN, 8'h7F, cic_pkg::GRP_SERIAL, 8'h00,
            1'b0, 0, '0, '0, '0);
    add_row(cic_pkg::REQ_LINE, REG_FILE_BASE, 8'h00, cic_pkg::GRP_SLOT, 8'hFF,
            1'b0, 0, '0, '0, '0);

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) push_request(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // Three random runs: receiver-heavy gaps, sender-heavy gaps, then full rate.
    // Hold off the sender between runs until every result is back.
    for (int run = 0; run < 3; run++) begin
      send_idle_pct = (run == 0) ? 32 : (run == 1) ? 61 : 0;
      recv_idle_pct = (run == 0) ? 61 : (run == 1) ? 32 : 0;
      for (int n = 0; n < ITEMS_PER_RUN; n++) push_request(random_request(), 1'b0, '0);
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    $display("covered %0d reads, %0d writes, %0d line changes and %0d acknowledges;",
             n_reads, n_writes, n_lines, n_acks);
    $display("%0d results compared, %0d with the CPU request raised", checked, n_rises);
    if (mismatches == 0) begin
      $display("cascaded_interrupt_controller_tb: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("cascaded_interrupt_controller_tb: errors");
    end
    $finish;
  end

endmodule
